### src/gso_pkg.sv
// ----------------------------------------------------------------------------
// gso_pkg
// Shared types, constants and fixed-point helpers for the 3x3 orthonormalizer.
// ----------------------------------------------------------------------------
package gso_pkg;

  localparam int WW  = 34;   // working column element, Q16.16 with headroom
  localparam int UW  = 32;   // unit vector element, Q1.30
  localparam int MW  = 33;   // magnitude of a working element
  localparam int NW  = 31;   // normalized magnitude
  localparam int SQW = 64;   // sum of squares / sqrt remainder
  localparam int RW  = 32;   // square root
  localparam int DVW = 62;   // division remainder
  localparam int PW  = 66;   // product of unit and working element
  localparam int TW  = 36;   // product scaled down by 2^30
  localparam int AW  = 38;   // accumulation width before saturation
  localparam int FRAC = 30;
  localparam int NSQ  = 32;  // sqrt stages, one root bit each
  localparam int NDV  = 31;  // divide stages, one quotient bit each

  localparam logic signed [WW-1:0] SAT_MAX = 34'sh1_FFFF_FFFF;
  localparam logic signed [AW-1:0] SAT_HI  = 38'sh1_FFFF_FFFF;
  localparam logic signed [AW-1:0] SAT_LO  = -38'sh1_FFFF_FFFF;

  typedef logic signed [WW-1:0] wrk_t;
  typedef logic signed [UW-1:0] unit_t;
  typedef wrk_t  [2:0] wcol_t;
  typedef unit_t [2:0] ucol_t;

  // x / 2^30 with truncation toward zero
  function automatic logic signed [TW-1:0] tdiv30(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] b;
    b = x + (x[PW-1] ? PW'((66'sd1 <<< FRAC) - 66'sd1) : PW'(0));
    return $signed(b[PW-1:FRAC]);
  endfunction

  function automatic wrk_t sat34(input logic signed [AW-1:0] x);
    wrk_t r;
    if (x > SAT_HI)      r = SAT_MAX;
    else if (x < SAT_LO) r = -SAT_MAX;
    else                 r = x[WW-1:0];
    return r;
  endfunction

endpackage

### src/gso_unit.sv
// ----------------------------------------------------------------------------
// gso_unit
// Pipelined column normalizer: magnitude, block scaling, sum of squares,
// bit-per-stage square root and bit-per-stage division into Q1.30.
// ----------------------------------------------------------------------------
module gso_unit #(
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vin,
  input  gso_pkg::wcol_t      w,
  input  logic [SW-1:0]       sin,
  output logic                vout,
  output gso_pkg::ucol_t      u,
  output logic                ok,
  output logic [SW-1:0]       sout
);
  import gso_pkg::*;

  // stage A: magnitudes and max
  logic          a_v;
  logic [MW-1:0] a_mag [3];
  logic [2:0]    a_neg;
  logic [MW-1:0] a_mx;
  logic [SW-1:0] a_side;
  logic [MW-1:0] mag_c [3];
  logic [MW-1:0] mx_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = w[k][WW-1] ? MW'(-w[k]) : MW'(w[k]);
    end
    mx_c = mag_c[0];
    if (mag_c[1] > mx_c) mx_c = mag_c[1];
    if (mag_c[2] > mx_c) mx_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= vin;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_mag[k] <= mag_c[k];
        a_neg[k] <= w[k][WW-1];
      end
      a_mx   <= mx_c;
      a_side <= sin;
    end
  end

  // stage B: leading one of the max
  logic          b_v;
  logic [MW-1:0] b_mag [3];
  logic [2:0]    b_neg;
  logic          b_ok;
  logic [5:0]    b_pos;
  logic [SW-1:0] b_side;
  logic [5:0]    pos_c;

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < MW; i++) begin
      if (a_mx[i]) pos_c = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= a_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_mag  <= a_mag;
      b_neg  <= a_neg;
      b_ok   <= (a_mx != '0);
      b_pos  <= pos_c;
      b_side <= a_side;
    end
  end

  // stage C: shift so the max lands in [2^30, 2^31)
  logic          c_v;
  logic [NW-1:0] c_n [3];
  logic [2:0]    c_neg;
  logic          c_ok;
  logic [SW-1:0] c_side;
  logic [MW-1:0] sh_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (b_pos >= 6'(FRAC)) sh_c[k] = b_mag[k] >> (b_pos - 6'(FRAC));
      else                   sh_c[k] = b_mag[k] << (6'(FRAC) - b_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= b_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) c_n[k] <= sh_c[k][NW-1:0];
      c_neg  <= b_neg;
      c_ok   <= b_ok;
      c_side <= b_side;
    end
  end

  // stage D: squares
  logic            d_v;
  logic [NW-1:0]   d_n [3];
  logic [2*NW-1:0] d_sq [3];
  logic [2:0]      d_neg;
  logic            d_ok;
  logic [SW-1:0]   d_side;

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (en) d_v <= c_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) d_sq[k] <= c_n[k] * c_n[k];
      d_n    <= c_n;
      d_neg  <= c_neg;
      d_ok   <= c_ok;
      d_side <= c_side;
    end
  end

  // square root pipeline, index 0 loaded with the sum of squares
  logic           sq_v    [0:NSQ];
  logic [SQW-1:0] sq_rem  [0:NSQ];
  logic [SQW-1:0] sq_root [0:NSQ];
  logic [NW-1:0]  sq_n    [0:NSQ][3];
  logic [2:0]     sq_neg  [0:NSQ];
  logic           sq_ok   [0:NSQ];
  logic [SW-1:0]  sq_side [0:NSQ];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= d_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= SQW'(d_sq[0]) + SQW'(d_sq[1]) + SQW'(d_sq[2]);
      sq_root[0] <= '0;
      sq_n[0]    <= d_n;
      sq_neg[0]  <= d_neg;
      sq_ok[0]   <= d_ok;
      sq_side[0] <= d_side;
    end
  end

  for (genvar t = 0; t < NSQ; t++) begin : g_sq
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (NSQ - 1 - t));
    logic [SQW-1:0] trial;
    assign trial = sq_root[t] + BIT;

    always_ff @(posedge clk) begin
      if (rst) sq_v[t+1] <= 1'b0;
      else if (en) sq_v[t+1] <= sq_v[t];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_rem[t] >= trial) begin
          sq_rem[t+1]  <= sq_rem[t] - trial;
          sq_root[t+1] <= (sq_root[t] >> 1) + BIT;
        end else begin
          sq_rem[t+1]  <= sq_rem[t];
          sq_root[t+1] <= sq_root[t] >> 1;
        end
        sq_n[t+1]    <= sq_n[t];
        sq_neg[t+1]  <= sq_neg[t];
        sq_ok[t+1]   <= sq_ok[t];
        sq_side[t+1] <= sq_side[t];
      end
    end
  end

  // divide pipeline: q = (n << 30) / r, q never above 2^30
  logic           dv_v    [0:NDV];
  logic [DVW-1:0] dv_rem  [0:NDV][3];
  logic [NW-1:0]  dv_q    [0:NDV][3];
  logic [RW-1:0]  dv_r    [0:NDV];
  logic [2:0]     dv_neg  [0:NDV];
  logic           dv_ok   [0:NDV];
  logic [SW-1:0]  dv_side [0:NDV];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= sq_v[NSQ];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k] <= {1'b0, sq_n[NSQ][k], FRAC'(0)};
        dv_q[0][k]   <= '0;
      end
      dv_r[0]    <= sq_root[NSQ][RW-1:0];
      dv_neg[0]  <= sq_neg[NSQ];
      dv_ok[0]   <= sq_ok[NSQ];
      dv_side[0] <= sq_side[NSQ];
    end
  end

  for (genvar t = 0; t < NDV; t++) begin : g_dv
    localparam int SH = NDV - 1 - t;
    logic [DVW-1:0] sub;
    assign sub = DVW'(dv_r[t]) << SH;

    always_ff @(posedge clk) begin
      if (rst) dv_v[t+1] <= 1'b0;
      else if (en) dv_v[t+1] <= dv_v[t];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (dv_rem[t][k] >= sub) begin
            dv_rem[t+1][k] <= dv_rem[t][k] - sub;
            dv_q[t+1][k]   <= dv_q[t][k] | (NW'(1) << SH);
          end else begin
            dv_rem[t+1][k] <= dv_rem[t][k];
            dv_q[t+1][k]   <= dv_q[t][k];
          end
        end
        dv_r[t+1]    <= dv_r[t];
        dv_neg[t+1]  <= dv_neg[t];
        dv_ok[t+1]   <= dv_ok[t];
        dv_side[t+1] <= dv_side[t];
      end
    end
  end

  // sign and zero-column masking
  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else if (en) vout <= dv_v[NDV];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (!dv_ok[NDV])        u[k] <= '0;
        else if (dv_neg[NDV][k]) u[k] <= -$signed(UW'(dv_q[NDV][k]));
        else                    u[k] <= $signed(UW'(dv_q[NDV][k]));
      end
      ok   <= dv_ok[NDV];
      sout <= dv_side[NDV];
    end
  end

endmodule

### src/gso_proj.sv
// ----------------------------------------------------------------------------
// gso_proj
// Removes the projection onto one unit vector from NC working columns.
// Four stages: products, dot sum, scaled products, subtract and saturate.
// ----------------------------------------------------------------------------
module gso_proj #(
  parameter int NC = 1,
  parameter int SW = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vin,
  input  gso_pkg::ucol_t             u,
  input  gso_pkg::wcol_t [NC-1:0]    w,
  input  logic [SW-1:0]              sin,
  output logic                       vout,
  output gso_pkg::wcol_t [NC-1:0]    wout,
  output logic [SW-1:0]              sout
);
  import gso_pkg::*;

  logic                 p1_v, p2_v, p3_v;
  ucol_t                p1_u, p2_u;
  wcol_t [NC-1:0]       p1_w, p2_w, p3_w;
  logic signed [PW-1:0] p1_pr [NC][3];
  logic signed [PW-1:0] p3_e  [NC][3];
  wrk_t                 p2_d  [NC];
  logic [SW-1:0]        p1_side, p2_side, p3_side;
  logic signed [AW-1:0] dsum_c [NC];
  logic signed [AW-1:0] diff_c [NC][3];

  // stage 1: u_k * w_k
  always_ff @(posedge clk) begin
    if (rst) p1_v <= 1'b0;
    else if (en) p1_v <= vin;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NC; j++)
        for (int k = 0; k < 3; k++)
          p1_pr[j][k] <= PW'($signed(u[k]) * $signed(w[j][k]));
      p1_u    <= u;
      p1_w    <= w;
      p1_side <= sin;
    end
  end

  // stage 2: dot product, each term truncated
  always_comb begin
    for (int j = 0; j < NC; j++) begin
      dsum_c[j] = AW'(tdiv30(p1_pr[j][0])) + AW'(tdiv30(p1_pr[j][1]))
                + AW'(tdiv30(p1_pr[j][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) p2_v <= 1'b0;
    else if (en) p2_v <= p1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NC; j++) p2_d[j] <= sat34(dsum_c[j]);
      p2_u    <= p1_u;
      p2_w    <= p1_w;
      p2_side <= p1_side;
    end
  end

  // stage 3: d * u_k
  always_ff @(posedge clk) begin
    if (rst) p3_v <= 1'b0;
    else if (en) p3_v <= p2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NC; j++)
        for (int k = 0; k < 3; k++)
          p3_e[j][k] <= PW'($signed(p2_d[j]) * $signed(p2_u[k]));
      p3_w    <= p2_w;
      p3_side <= p2_side;
    end
  end

  // stage 4: subtract and saturate
  always_comb begin
    for (int j = 0; j < NC; j++)
      for (int k = 0; k < 3; k++)
        diff_c[j][k] = AW'($signed(p3_w[j][k])) - AW'(tdiv30(p3_e[j][k]));
  end

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else if (en) vout <= p3_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NC; j++)
        for (int k = 0; k < 3; k++)
          wout[j][k] <= sat34(diff_c[j][k]);
      sout <= p3_side;
    end
  end

endmodule

### src/gram_schmidt_orthonormalize_3x3.sv
// Pipeline from an accepted word to its result word: three column normalizers,
//   two projection stages and one output register; its depth is set by the
//   bit-per-stage sqrt and divide chains.
// Throughput: one matrix per cycle; a stall at the output freezes the pipe.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// gram_schmidt_orthonormalize_3x3
// Modified Gram-Schmidt on a Q16.16 3x3 matrix, Q1.30 orthonormal output.
// ----------------------------------------------------------------------------
module gram_schmidt_orthonormalize_3x3 (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_c0_x,
  input  logic signed [31:0] in_c0_y,
  input  logic signed [31:0] in_c0_z,
  input  logic signed [31:0] in_c1_x,
  input  logic signed [31:0] in_c1_y,
  input  logic signed [31:0] in_c1_z,
  input  logic signed [31:0] in_c2_x,
  input  logic signed [31:0] in_c2_y,
  input  logic signed [31:0] in_c2_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_c0_x,
  output logic signed [31:0] out_c0_y,
  output logic signed [31:0] out_c0_z,
  output logic signed [31:0] out_c1_x,
  output logic signed [31:0] out_c1_y,
  output logic signed [31:0] out_c1_z,
  output logic signed [31:0] out_c2_x,
  output logic signed [31:0] out_c2_y,
  output logic signed [31:0] out_c2_z,
  output logic               degenerate
);
  import gso_pkg::*;

  localparam int UCW = $bits(ucol_t);
  localparam int WCW = $bits(wcol_t);
  localparam int SW0 = 2 * WCW;
  localparam int SWA = UCW + 1;
  localparam int SW1 = UCW + 1 + WCW;
  localparam int SWB = 2 * (UCW + 1);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  wcol_t w0, w1, w2;
  assign w0 = {wrk_t'(in_c0_z), wrk_t'(in_c0_y), wrk_t'(in_c0_x)};
  assign w1 = {wrk_t'(in_c1_z), wrk_t'(in_c1_y), wrk_t'(in_c1_x)};
  assign w2 = {wrk_t'(in_c2_z), wrk_t'(in_c2_y), wrk_t'(in_c2_x)};

  // column 0
  logic           n0_v, n0_ok;
  ucol_t          n0_u;
  logic [SW0-1:0] n0_side;

  gso_unit #(.SW(SW0)) u_unit0 (
    .clk(clk), .rst(rst), .en(en), .vin(in_valid && en), .w(w0),
    .sin({w1, w2}), .vout(n0_v), .u(n0_u), .ok(n0_ok), .sout(n0_side)
  );

  // remove column 0 from columns 1 and 2; index 1 is column 1
  logic           pa_v;
  wcol_t [1:0]    pa_w;
  logic [SWA-1:0] pa_side;

  gso_proj #(.NC(2), .SW(SWA)) u_proj_a (
    .clk(clk), .rst(rst), .en(en), .vin(n0_v), .u(n0_u),
    .w(n0_side), .sin({n0_u, n0_ok}),
    .vout(pa_v), .wout(pa_w), .sout(pa_side)
  );

  // column 1
  logic           n1_v, n1_ok;
  ucol_t          n1_u;
  logic [SW1-1:0] n1_side;

  gso_unit #(.SW(SW1)) u_unit1 (
    .clk(clk), .rst(rst), .en(en), .vin(pa_v), .w(pa_w[1]),
    .sin({pa_side, pa_w[0]}), .vout(n1_v), .u(n1_u), .ok(n1_ok), .sout(n1_side)
  );

  // remove column 1 from column 2
  logic           pb_v;
  wcol_t [0:0]    pb_w;
  logic [SWB-1:0] pb_side;

  gso_proj #(.NC(1), .SW(SWB)) u_proj_b (
    .clk(clk), .rst(rst), .en(en), .vin(n1_v), .u(n1_u),
    .w(n1_side[WCW-1:0]), .sin({n1_side[SW1-1:WCW], n1_u, n1_ok}),
    .vout(pb_v), .wout(pb_w), .sout(pb_side)
  );

  // column 2
  logic           n2_v, n2_ok;
  ucol_t          n2_u;
  logic [SWB-1:0] n2_side;

  gso_unit #(.SW(SWB)) u_unit2 (
    .clk(clk), .rst(rst), .en(en), .vin(pb_v), .w(pb_w[0]),
    .sin(pb_side), .vout(n2_v), .u(n2_u), .ok(n2_ok), .sout(n2_side)
  );

  // output word register; side layout is {u0, ok0, u1, ok1}
  ucol_t r_u0, r_u1;
  assign r_u0 = n2_side[SWB-1 -: UCW];
  assign r_u1 = n2_side[UCW:1];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= n2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_c0_x   <= r_u0[0];
      out_c0_y   <= r_u0[1];
      out_c0_z   <= r_u0[2];
      out_c1_x   <= r_u1[0];
      out_c1_y   <= r_u1[1];
      out_c1_z   <= r_u1[2];
      out_c2_x   <= n2_u[0];
      out_c2_y   <= n2_u[1];
      out_c2_z   <= n2_u[2];
      degenerate <= !(n2_side[SWB-UCW-1] && n2_side[0] && n2_ok);
    end
  end

  logic z0, z1, z2;
  assign z0 = (out_c0_x == 0) && (out_c0_y == 0) && (out_c0_z == 0);
  assign z1 = (out_c1_x == 0) && (out_c1_y == 0) && (out_c1_z == 0);
  assign z2 = (out_c2_x == 0) && (out_c2_y == 0) && (out_c2_z == 0);

  a_degen_has_zero_col: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> z0 || z1 || z2)
    else $error("degenerate word without a zero column");

  a_good_cols_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> !z0 && !z1 && !z2)
    else $error("zero column without degenerate flag");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_c0_x <= 32'sd1073741824 && out_c0_x >= -32'sd1073741824
               && out_c1_y <= 32'sd1073741824 && out_c1_y >= -32'sd1073741824
               && out_c2_z <= 32'sd1073741824 && out_c2_z >= -32'sd1073741824)
    else $error("unit element outside Q1.30 range");

endmodule
